>>> hdl/wavp_pkg.sv
// ----------------------------------------------------------------------------
// WAV header parser package
// Shared constants, parse phase codes and controller/datapath link types.
// ----------------------------------------------------------------------------
package wavp_pkg;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam logic [15:0] DefChannels = 16'd2;
  localparam logic [31:0] DefRate     = 32'd44100;
  localparam logic [15:0] DefBits     = 16'd16;
  localparam logic [31:0] FmtBodyLen  = 32'd16;
  localparam logic [9:0]  MsPerSec    = 10'd1000;

  localparam int unsigned DivW   = 42;
  localparam int unsigned DivCntW = 6;
  localparam logic [DivCntW-1:0] DivLastBit = DivCntW'(DivW - 1);
  localparam logic [30:0] DurMax = 31'h7FFF_FFFF;

  localparam logic [3:0] PH_RIFF  = 4'd0;
  localparam logic [3:0] PH_FSIZE = 4'd1;
  localparam logic [3:0] PH_WAVE  = 4'd2;
  localparam logic [3:0] PH_CID   = 4'd3;
  localparam logic [3:0] PH_CLEN  = 4'd4;
  localparam logic [3:0] PH_FMT   = 4'd5;
  localparam logic [3:0] PH_DATA  = 4'd6;
  localparam logic [3:0] PH_SKIP  = 4'd7;
  localparam logic [3:0] PH_IDLE  = 4'd8;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_RIFF  = 3'd1;
  localparam logic [2:0] ST_BAD_WAVE  = 3'd2;
  localparam logic [2:0] ST_NO_DATA   = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;
  localparam logic [2:0] ST_ZERO_DIV  = 3'd5;

  localparam int unsigned OutDataW = 144;

  typedef struct packed {
    logic step;
    logic div_start;
    logic show_pay;
    logic show_stat;
  } wavp_cmd_t;

  typedef struct packed {
    logic pay_now;
    logic stat_now;
    logic need_now;
    logic stat_q;
    logic need_q;
    logic div_busy;
  } wavp_sts_t;

endpackage

>>> hdl/wavp_ctrl.sv
// ----------------------------------------------------------------------------
// WAV header parser controller
// Handshake sequencing: accept an item, show its payload and status results,
// run the duration divider before a good status.
// ----------------------------------------------------------------------------
module wavp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  wavp_pkg::wavp_sts_t sts_i,
  output wavp_pkg::wavp_cmd_t cmd_o
);
  import wavp_pkg::*;

  localparam logic [2:0] S_IN   = 3'd0;
  localparam logic [2:0] S_PAY  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_STAT = 3'd4;

  logic [2:0] state_q, state_d;
  logic       in_acc, out_acc;

  assign s_axis_tready = (state_q == S_IN);
  assign m_axis_tvalid = (state_q == S_PAY) || (state_q == S_STAT);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  assign cmd_o.step      = in_acc;
  assign cmd_o.div_start = (state_q == S_LOAD);
  assign cmd_o.show_pay  = (state_q == S_PAY);
  assign cmd_o.show_stat = (state_q == S_STAT);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IN: begin
        if (in_acc) begin
          if (sts_i.pay_now) state_d = S_PAY;
          else if (sts_i.stat_now) state_d = sts_i.need_now ? S_LOAD : S_STAT;
        end
      end
      S_PAY: begin
        if (out_acc) begin
          if (!sts_i.stat_q) state_d = S_IN;
          else state_d = sts_i.need_q ? S_LOAD : S_STAT;
        end
      end
      S_LOAD: state_d = S_DIV;
      S_DIV: begin
        if (!sts_i.div_busy) state_d = S_STAT;
      end
      S_STAT: begin
        if (out_acc) state_d = S_IN;
      end
      default: state_d = S_IN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IN;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");
  a_load_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |=> (state_q == S_DIV && sts_i.div_busy))
    else $error("divider not started");
  a_quiet_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !sts_i.pay_now && !sts_i.stat_now) |=> s_axis_tready)
    else $error("resultless item stalled input");

endmodule

>>> hdl/wavp_dp.sv
// ----------------------------------------------------------------------------
// WAV header parser datapath
// Chunk walking registers, result plan, shared bit-serial duration divider
// and result formatting.
// ----------------------------------------------------------------------------
module wavp_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [7:0]                        byte_i,
  input  logic                              eof_i,
  input  wavp_pkg::wavp_cmd_t               cmd_i,
  output wavp_pkg::wavp_sts_t               sts_o,
  output logic [wavp_pkg::OutDataW-1:0]     tdata_o,
  output logic                              kind_o,
  output logic                              last_o
);
  import wavp_pkg::*;

  logic [3:0]  phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [15:0] ch_q, ch_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;

  logic [31:0] tag_new, rem_dec;
  logic        pay, st_en;
  logic [2:0]  code;
  logic [31:0] size;
  logic        zero_div;

  logic [7:0]  pay_q;
  logic        stat_q, need_q;
  logic [2:0]  code_q;
  logic [31:0] size_q, srate_q;
  logic [15:0] sch_q, sbits_q;

  logic [DivW-1:0]    quo_q, quo_d;
  logic [31:0]        drem_q, drem_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [1:0]         pass_q, pass_d;
  logic               busy_q, busy_d;
  logic [31:0]        dvs;
  logic [32:0]        trial;
  logic               qbit;
  logic [30:0]        dur;

  assign tag_new = (idx_q == 4'd0) ? {24'd0, byte_i}
                 : (tag_q | ({24'd0, byte_i} << {idx_q[1:0], 3'b000}));
  assign rem_dec = (rem_q != 32'd0) ? rem_q - 32'd1 : rem_q;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    rem_d   = rem_q;
    tag_d   = tag_q;
    len_d   = len_q;
    ch_d    = ch_q;
    rate_d  = rate_q;
    bits_d  = bits_q;
    pay     = 1'b0;
    st_en   = 1'b0;
    code    = ST_OK;
    size    = 32'd0;
    case (phase_q)
      PH_RIFF, PH_FSIZE, PH_WAVE, PH_CID, PH_CLEN: begin
        tag_d = tag_new;
        if (idx_q < 4'd3) begin
          idx_d = idx_q + 4'd1;
        end else begin
          idx_d = 4'd0;
          case (phase_q)
            PH_RIFF: begin
              if (tag_new == TagRiff) phase_d = PH_FSIZE;
              else begin
                st_en = 1'b1; code = ST_BAD_RIFF; phase_d = PH_IDLE;
              end
            end
            PH_FSIZE: phase_d = PH_WAVE;
            PH_WAVE: begin
              if (tag_new == TagWave) phase_d = PH_CID;
              else begin
                st_en = 1'b1; code = ST_BAD_WAVE; phase_d = PH_IDLE;
              end
            end
            PH_CID: begin
              rem_d = tag_new; phase_d = PH_CLEN;
            end
            default: begin
              len_d = tag_new;
              tag_d = rem_q;
              rem_d = tag_new;
              if (rem_q == TagFmt) phase_d = PH_FMT;
              else if (rem_q == TagData) begin
                if (tag_new == 32'd0) begin
                  st_en = 1'b1; code = ST_NO_DATA; phase_d = PH_IDLE;
                end else phase_d = PH_DATA;
              end else phase_d = (tag_new == 32'd0) ? PH_CID : PH_SKIP;
            end
          endcase
        end
      end
      PH_FMT: begin
        case (idx_q)
          4'd2:  ch_d[7:0]    = byte_i;
          4'd3:  ch_d[15:8]   = byte_i;
          4'd4:  rate_d[7:0]  = byte_i;
          4'd5:  rate_d[15:8] = byte_i;
          4'd6:  rate_d[23:16] = byte_i;
          4'd7:  rate_d[31:24] = byte_i;
          4'd14: bits_d[7:0]  = byte_i;
          4'd15: bits_d[15:8] = byte_i;
          default: ;
        endcase
        if (idx_q != 4'd15) begin
          idx_d = idx_q + 4'd1;
        end else begin
          idx_d = 4'd0;
          if (len_q > FmtBodyLen) begin
            rem_d = len_q - FmtBodyLen; phase_d = PH_SKIP;
          end else phase_d = PH_CID;
        end
      end
      PH_SKIP: begin
        rem_d = rem_dec;
        if (rem_dec == 32'd0) phase_d = PH_CID;
      end
      PH_DATA: begin
        pay   = 1'b1;
        rem_d = rem_dec;
        if (rem_dec == 32'd0) begin
          st_en = 1'b1; code = zero_div ? ST_ZERO_DIV : ST_OK;
          size = len_q; phase_d = PH_IDLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
    if (eof_i) begin
      case (phase_d)
        PH_RIFF: begin
          st_en = 1'b1; code = ST_BAD_RIFF;
        end
        PH_FSIZE, PH_WAVE: begin
          st_en = 1'b1; code = ST_BAD_WAVE;
        end
        PH_DATA: begin
          st_en = 1'b1; code = ST_TRUNCATED; size = len_q;
        end
        PH_IDLE: ;
        default: begin
          st_en = 1'b1; code = ST_NO_DATA;
        end
      endcase
    end
  end

  assign zero_div = (rate_q == 32'd0) || (ch_q == 16'd0) || (bits_q[15:3] == 13'd0);

  assign sts_o.pay_now  = pay;
  assign sts_o.stat_now = st_en;
  assign sts_o.need_now = st_en && (code == ST_OK);
  assign sts_o.stat_q   = stat_q;
  assign sts_o.need_q   = need_q;
  assign sts_o.div_busy = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      idx_q   <= 4'd0;
      rem_q   <= 32'd0;
      tag_q   <= 32'd0;
      len_q   <= 32'd0;
      ch_q    <= DefChannels;
      rate_q  <= DefRate;
      bits_q  <= DefBits;
      stat_q  <= 1'b0;
      need_q  <= 1'b0;
    end else if (cmd_i.step) begin
      stat_q <= st_en;
      need_q <= st_en && (code == ST_OK);
      if (eof_i) begin
        phase_q <= PH_RIFF;
        idx_q   <= 4'd0;
        rem_q   <= 32'd0;
        tag_q   <= 32'd0;
        len_q   <= 32'd0;
        ch_q    <= DefChannels;
        rate_q  <= DefRate;
        bits_q  <= DefBits;
      end else begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
        rem_q   <= rem_d;
        tag_q   <= tag_d;
        len_q   <= len_d;
        ch_q    <= ch_d;
        rate_q  <= rate_d;
        bits_q  <= bits_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      pay_q   <= byte_i;
      code_q  <= code;
      size_q  <= size;
      sch_q   <= ch_d;
      srate_q <= rate_d;
      sbits_q <= bits_d;
    end
  end

  always_comb begin
    case (pass_q)
      2'd0:    dvs = srate_q;
      2'd1:    dvs = {16'd0, sch_q};
      default: dvs = {19'd0, sbits_q[15:3]};
    endcase
  end

  assign trial = {drem_q, quo_q[DivW-1]};
  assign qbit  = (trial >= {1'b0, dvs});

  always_comb begin
    quo_d  = quo_q;
    drem_d = drem_q;
    cnt_d  = cnt_q;
    pass_d = pass_q;
    busy_d = busy_q;
    if (cmd_i.div_start) begin
      quo_d  = DivW'(size_q) * DivW'(MsPerSec);
      drem_d = 32'd0;
      cnt_d  = '0;
      pass_d = 2'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d  = {quo_q[DivW-2:0], qbit};
      drem_d = qbit ? 32'(trial - {1'b0, dvs}) : trial[31:0];
      if (cnt_q == DivLastBit) begin
        cnt_d  = '0;
        drem_d = 32'd0;
        if (pass_q == 2'd2) busy_d = 1'b0;
        else pass_d = pass_q + 2'd1;
      end else begin
        cnt_d = cnt_q + DivCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    drem_q <= drem_d;
    cnt_q  <= cnt_d;
    pass_q <= pass_d;
  end

  assign dur = (code_q != ST_OK) ? 31'd0
             : ((quo_q > DivW'(DurMax)) ? DurMax : quo_q[30:0]);

  always_comb begin
    tdata_o = '0;
    kind_o  = 1'b0;
    last_o  = 1'b0;
    if (cmd_i.show_stat) begin
      kind_o  = 1'b1;
      last_o  = 1'b1;
      tdata_o = {6'd0, dur, size_q, sbits_q, srate_q, sch_q, code_q, 8'd0};
    end else if (cmd_i.show_pay) begin
      last_o  = !stat_q;
      tdata_o = {136'd0, pay_q};
    end
  end

endmodule

>>> hdl/wav_header_chunk_parser_top.sv
// ----------------------------------------------------------------------------
// WAV header chunk parser
// Byte-stream RIFF/WAVE parser: emits data chunk bytes and one status item.
// ----------------------------------------------------------------------------
// Feed the file one byte per item, tlast on its final byte. A byte that makes
// no result leaves the input ready; a data byte is held as a payload item
// until the output takes it, and no new byte is taken meanwhile. The good
// status after a full data chunk waits on a one-bit-a-cycle restoring divider
// that divides 1000*size by rate, channels and bytes per sample in turn, and
// is shown once the divider is done.
module wav_header_chunk_parser_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // byte_in
  input  logic         s_axis_tlast,   // end_of_file
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // payload, status, channels, sample_rate, bits_per_sample, data_size,
  // duration_ms, zero fill
  output logic [wavp_pkg::OutDataW-1:0] m_axis_tdata,
  output logic         m_axis_tuser,   // kind
  output logic         m_axis_tlast    // last_of_run
);
  import wavp_pkg::*;

  wavp_cmd_t cmd;
  wavp_sts_t sts;

  wavp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  wavp_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (s_axis_tdata),
    .eof_i   (s_axis_tlast),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .tdata_o (m_axis_tdata),
    .kind_o  (m_axis_tuser),
    .last_o  (m_axis_tlast)
  );

endmodule

>>> sim/tb_wav_header_chunk_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header chunk parser testbench
// Streams whole and broken WAV files into the parser one byte per item and
// predicts every payload byte and status item. Results are compared field by
// field in order, with random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_wav_header_chunk_parser_top;
  import wavp_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload;
    logic [2:0]  status;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] size;
    logic [30:0] dur_ms;
    logic        last;
  } wav_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  wav_header_chunk_parser_top u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  initial forever #1 clk_i = ~clk_i;

  // parser state mirror
  logic [3:0]  phase;
  logic [3:0]  byte_idx;
  logic [31:0] remain, tag_acc, chunk_len;
  logic [15:0] chan_q, bits_q;
  logic [31:0] rate_q;

  wav_result_t expected_q[$];
  int errors = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int results_seen = 0;
  int status_seen[8];
  bit idle_en = 1'b1;
  int hold_cycles = 0;
  byte file_buf[$];

  function automatic void reset_mirror();
    phase = PH_RIFF; byte_idx = '0; remain = '0; tag_acc = '0; chunk_len = '0;
    chan_q = DefChannels; rate_q = DefRate; bits_q = DefBits;
  endfunction

  function automatic void push_status(logic [2:0] st, logic [31:0] size);
    wav_result_t r;
    logic [63:0] dv, q;
    r = '0;
    r.kind = 1'b1; r.status = st; r.channels = chan_q; r.rate = rate_q;
    r.bits = bits_q; r.size = size;
    if (st == ST_OK) begin
      dv = 64'(rate_q) * 64'(chan_q) * 64'(bits_q / 16'd8);
      if (dv != 0) begin
        q = (64'd1000 * 64'(size)) / dv;
        r.dur_ms = (q > 64'(DurMax)) ? DurMax : q[30:0];
      end
    end
    expected_q.push_back(r);
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic eof);
    int n0;
    logic [31:0] id;
    logic [63:0] dv;
    wav_result_t r;
    n0 = expected_q.size();
    case (phase)
      PH_RIFF, PH_FSIZE, PH_WAVE, PH_CID, PH_CLEN: begin
        if (byte_idx == 0) tag_acc = '0;
        tag_acc |= 32'(b) << (8 * byte_idx[1:0]);
        if (byte_idx < 3) byte_idx++;
        else begin
          byte_idx = '0;
          if (phase == PH_RIFF) begin
            if (tag_acc == TagRiff) phase = PH_FSIZE;
            else begin push_status(ST_BAD_RIFF, '0); phase = PH_IDLE; end
          end else if (phase == PH_FSIZE) phase = PH_WAVE;
          else if (phase == PH_WAVE) begin
            if (tag_acc == TagWave) phase = PH_CID;
            else begin push_status(ST_BAD_WAVE, '0); phase = PH_IDLE; end
          end else if (phase == PH_CID) begin
            remain = tag_acc; phase = PH_CLEN;
          end else begin
            id = remain; chunk_len = tag_acc; tag_acc = id; remain = chunk_len;
            if (id == TagFmt) phase = PH_FMT;
            else if (id == TagData) begin
              if (chunk_len == 0) begin push_status(ST_NO_DATA, '0); phase = PH_IDLE; end
              else phase = PH_DATA;
            end else phase = (chunk_len == 0) ? PH_CID : PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        case (byte_idx)
          4'd2: chan_q[7:0] = b;
          4'd3: chan_q[15:8] = b;
          4'd4: rate_q[7:0] = b;
          4'd5: rate_q[15:8] = b;
          4'd6: rate_q[23:16] = b;
          4'd7: rate_q[31:24] = b;
          4'd14: bits_q[7:0] = b;
          4'd15: bits_q[15:8] = b;
          default: ;
        endcase
        if (byte_idx < 15) byte_idx++;
        else begin
          byte_idx = '0;
          if (chunk_len > FmtBodyLen) begin remain = chunk_len - FmtBodyLen; phase = PH_SKIP; end
          else phase = PH_CID;
        end
      end
      PH_SKIP: begin
        if (remain != 0) remain--;
        if (remain == 0) phase = PH_CID;
      end
      PH_DATA: begin
        r = '0; r.payload = b;
        expected_q.push_back(r);
        if (remain != 0) remain--;
        if (remain == 0) begin
          dv = 64'(rate_q) * 64'(chan_q) * 64'(bits_q / 16'd8);
          push_status(dv == 0 ? ST_ZERO_DIV : ST_OK, chunk_len);
          phase = PH_IDLE;
        end
      end
      default: phase = PH_IDLE;
    endcase
    if (eof) begin
      case (phase)
        PH_RIFF: push_status(ST_BAD_RIFF, '0);
        PH_FSIZE, PH_WAVE: push_status(ST_BAD_WAVE, '0);
        PH_DATA: push_status(ST_TRUNCATED, chunk_len);
        PH_IDLE: ;
        default: push_status(ST_NO_DATA, '0);
      endcase
      reset_mirror();
    end
    if (expected_q.size() > n0) expected_q[$].last = 1'b1;
  endfunction

  task automatic send_byte(logic [7:0] b, logic eof);
    @(negedge clk_i);
    while (idle_en && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= eof;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_byte(b, eof);
    bytes_sent++;
    if (eof) files_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_buf.size(); i++)
      send_byte(file_buf[i], i == file_buf.size() - 1);
    file_buf.delete();
  endtask

  task automatic add_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) file_buf.push_back(w[8*i +: 8]);
  endtask

  task automatic add_fmt(logic [31:0] len, logic [15:0] ch, logic [31:0] rate,
                         logic [15:0] bits);
    add_word(TagFmt); add_word(len);
    file_buf.push_back(8'($urandom)); file_buf.push_back(8'($urandom));
    file_buf.push_back(ch[7:0]); file_buf.push_back(ch[15:8]);
    add_word(rate);
    for (int i = 0; i < 6; i++) file_buf.push_back(8'($urandom));
    file_buf.push_back(bits[7:0]); file_buf.push_back(bits[15:8]);
    for (int i = 16; i < len; i++) file_buf.push_back(8'($urandom));
  endtask

  task automatic add_data(logic [31:0] len, int body);
    add_word(TagData); add_word(len);
    for (int i = 0; i < body; i++) file_buf.push_back(8'($urandom));
  endtask

  task automatic add_head();
    add_word(TagRiff); add_word($urandom); add_word(TagWave);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (140) @(posedge clk_i);
  endtask

  task automatic test_directed();
    // extreme byte values, default format, one byte data chunk
    add_head(); add_data(1, 1); file_buf.push_back(8'hFF); send_file();
    add_head(); add_fmt(16, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF); add_data(2, 2); send_file();
    add_head(); add_fmt(16, 1, 1, 8); add_data(32'hFFFF_FFFF, 3); send_file();
    add_head(); add_fmt(4, 0, 8000, 16); add_data(2, 2); send_file();
    add_head(); add_fmt(20, 2, 0, 16); add_data(1, 1); send_file();
    add_head(); add_fmt(16, 2, 8000, 7); add_data(1, 1); send_file();
    add_head(); add_word(32'h7473_696C); add_word(0); add_word(32'h6B6E_756A); add_word(3);
    repeat (3) file_buf.push_back(8'h00);
    add_data(0, 0); send_file();
    add_word(32'h4646_4953); send_file();
    add_word(TagRiff); add_word(0); add_word(32'h0000_0000); send_file();
    file_buf.push_back(8'h52); file_buf.push_back(8'h49); send_file();
    send_byte(8'h00, 1'b1);
    add_word(TagRiff); add_word(1); send_file();
    add_head(); send_file();
    add_head(); add_data(8, 3); send_file();
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    add_head(); add_fmt(16, 1, 8000, 8); add_data(40, 40); send_file();
    wait_drained();
  endtask

  task automatic test_random_files();
    int kind, dl;
    while (bytes_sent < 920) begin
      kind = $urandom_range(9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 14)) file_buf.push_back(8'($urandom));
        send_file();
        continue;
      end
      add_head();
      if ($urandom_range(3) == 0) begin
        add_word($urandom); add_word($urandom_range(0, 6));
        repeat (file_buf[$-3]) file_buf.push_back(8'($urandom));
      end
      if (kind != 1)
        add_fmt($urandom_range(8, 22), $urandom_range(0, 3) == 0 ? 16'($urandom) :
                16'($urandom_range(0, 8)), $urandom_range(0, 4) == 0 ? $urandom :
                $urandom_range(0, 96000), $urandom_range(0, 4) == 0 ? 16'($urandom) :
                16'(8 * $urandom_range(0, 4)));
      dl = $urandom_range(0, 12);
      if (kind == 2) add_data(dl + $urandom_range(1, 5), dl);
      else if (kind == 3) add_data($urandom, dl);
      else add_data(dl, dl);
      if (kind == 4 && file_buf.size() > 1) file_buf.pop_back();
      if ($urandom_range(2) == 0) repeat ($urandom_range(1, 3)) file_buf.push_back(8'($urandom));
      if (kind == 5) idle_en = 1'b0;
      send_file();
      idle_en = 1'b1;
    end
  endtask

  // output side: random stall and the long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else m_axis_tready <= !(idle_en && $urandom_range(99) < 8);
    end
  end

  initial begin
    wav_result_t got, exp_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = '0;
        got.kind = m_axis_tuser;
        {got.dur_ms, got.size, got.bits, got.rate, got.channels, got.status, got.payload} =
          m_axis_tdata[137:0];
        got.last = m_axis_tlast;
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("unexpected result item kind=%0d", got.kind);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.kind == 1'b1) status_seen[got.status]++;
          if (got.kind !== exp_r.kind) begin
            $error("kind exp %0d got %0d", exp_r.kind, got.kind); errors++; end
          if (got.payload !== exp_r.payload) begin
            $error("payload exp %0h got %0h", exp_r.payload, got.payload); errors++; end
          if (got.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, got.status); errors++; end
          if (got.channels !== exp_r.channels) begin
            $error("channels exp %0d got %0d", exp_r.channels, got.channels); errors++; end
          if (got.rate !== exp_r.rate) begin
            $error("sample_rate exp %0d got %0d", exp_r.rate, got.rate); errors++; end
          if (got.bits !== exp_r.bits) begin
            $error("bits_per_sample exp %0d got %0d", exp_r.bits, got.bits); errors++; end
          if (got.size !== exp_r.size) begin
            $error("data_size exp %0d got %0d", exp_r.size, got.size); errors++; end
          if (got.dur_ms !== exp_r.dur_ms) begin
            $error("duration_ms exp %0d got %0d", exp_r.dur_ms, got.dur_ms); errors++; end
          if (got.last !== exp_r.last) begin
            $error("last_of_run exp %0d got %0d", exp_r.last, got.last); errors++; end
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL wav_header_chunk_parser_top");
    $finish;
  end

  initial begin
    reset_mirror();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random_files();
    wait_drained();
    if (expected_q.size() != 0) errors++;
    $display("Sent %0d bytes in %0d files, checked %0d results", bytes_sent, files_sent,
             results_seen);
    $display("Status counts ok/riff/wave/nodata/trunc/zdiv: %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (errors == 0) $display("PASS wav_header_chunk_parser_top");
    else $display("FAIL wav_header_chunk_parser_top");
    $finish;
  end

endmodule

>>> files.f
hdl/wavp_pkg.sv
hdl/wavp_ctrl.sv
hdl/wavp_dp.sv
hdl/wav_header_chunk_parser_top.sv
sim/tb_wav_header_chunk_parser_top.sv
